/* src/xxh_pkg.sv */
// Shared constants, types and the rotate helper function of the XXH64 stream hasher.
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  localparam logic [5:0] StripeBytes = 6'd32;
  localparam logic [3:0] WordBytes   = 4'd8;

  typedef enum logic [3:0] {
    OP_FOLD_A, OP_FOLD_B,
    OP_MRG_A, OP_MRG_B, OP_MRG_C,
    OP_T8_A, OP_T8_B, OP_T8_C,
    OP_T4_A, OP_T4_B,
    OP_T1_A, OP_T1_B,
    OP_AV_A, OP_AV_B
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INSERT, ST_ISSUE, ST_MUL, ST_FIN, ST_ADDLEN, ST_TAIL, ST_EMIT
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       insert;
    logic       fold_prep;
    logic       add_len;
    logic       merge;
    logic       add_h_len;
    logic       mul_start;
    logic       emit;
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic pb_full;
    logic rem_nz;
    logic seen;
    logic last;
    logic t8;
    logic t4;
    logic t1;
    logic mul_done;
    logic out_free;
  } stat_t;

  // Rotate left by a constant amount in 1..63.
  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

/* src/xxhash64_stream_hasher_unit.sv */
// Top level of the XXH64 stream hasher: controller plus datapath.
// Items are taken one at a time: a word with no fold is accepted, inserted and added to
// the length; an empty word is accepted and added to the length. A stripe fold adds a start
// step plus 8 multiplies on one 64x64 multiplier built from three 32x32 steps. The last item
// runs the merge after a fold, the 8-byte tail words, the 4-byte and byte steps, the
// avalanche and the emit. Async low reset clears seed, state and valid.
`default_nettype none
module xxhash64_stream_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_value_o
);

  // Commands from the sequencer, status back from the datapath
  xxh_pkg::cmd_t  cmd;
  xxh_pkg::stat_t stat;

  // Sequencer: take an item, insert it into the stripe buffer, fold when full and
  // more bytes follow, and run the finish sequence on the last item.
  xxh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: hold the buffer, lanes, length and hash; the output register
  // keeps a finished hash while the next item is already taken.
  xxh_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .hash_value_o (hash_value_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
`default_nettype wire

/* src/xxh_mul.sv */
// Sequential 64x64 low-half multiplier built on one 32x32 multiplier.
`default_nettype none
module xxh_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);

  logic [63:0] a_q, b_q, p_q, p_d;
  logic [1:0]  step_q, step_d;
  logic        done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    case (step_q)
      2'd2:    begin ma = a_q[63:32]; mb = b_q[31:0];  end
      2'd3:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
      default: begin ma = a_q[31:0];  mb = b_q[31:0];  end
    endcase
    prod = {32'b0, ma} * {32'b0, mb};
    // first partial product is the full low product, cross terms add to the top half
    if (step_q == 2'd1) begin
      p_d = prod;
    end else begin
      p_d = {p_q[63:32] + prod[31:0], p_q[31:0]};
    end
    if (start_i) begin
      step_d = 2'd1;
    end else if (step_q == 2'd3) begin
      step_d = 2'd0;
    end else if (step_q != 2'd0) begin
      step_d = step_q + 2'd1;
    end else begin
      step_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (step_q != 2'd0) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule
`default_nettype wire

/* src/xxh_ctrl.sv */
// Controller state machine that sequences insert, fold, merge, tail, avalanche and emit.
`default_nettype none
module xxh_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire xxh_pkg::stat_t stat_i,
  output xxh_pkg::cmd_t       cmd_o
);

  xxh_pkg::state_e state_q, state_d;
  xxh_pkg::op_e    op_q, op_d;
  logic [1:0]      idx_q, idx_d;
  logic            fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xxh_pkg::ST_IDLE;
      op_q    <= xxh_pkg::OP_FOLD_A;
      idx_q   <= 2'd0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.op  = op_q;
    cmd_o.idx = idx_q;
    in_stall_o = (state_q != xxh_pkg::ST_IDLE);
    case (state_q)
      xxh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = xxh_pkg::ST_INSERT;
        end
      end
      xxh_pkg::ST_INSERT: begin
        if (stat_i.pb_full && stat_i.rem_nz) begin
          cmd_o.fold_prep = 1'b1;
          op_d    = xxh_pkg::OP_FOLD_A;
          idx_d   = 2'd0;
          state_d = xxh_pkg::ST_ISSUE;
        end else if (stat_i.rem_nz) begin
          cmd_o.insert = 1'b1;
        end else begin
          cmd_o.add_len = 1'b1;
          if (stat_i.last) begin
            fin_d   = 1'b1;
            state_d = xxh_pkg::ST_FIN;
          end else begin
            state_d = xxh_pkg::ST_IDLE;
          end
        end
      end
      xxh_pkg::ST_ISSUE: begin
        cmd_o.mul_start = 1'b1;
        state_d = xxh_pkg::ST_MUL;
      end
      xxh_pkg::ST_MUL: begin
        if (stat_i.mul_done) begin
          state_d = xxh_pkg::ST_ISSUE;
          case (op_q)
            xxh_pkg::OP_FOLD_A: op_d = xxh_pkg::OP_FOLD_B;
            xxh_pkg::OP_FOLD_B: begin
              if (idx_q != 2'd3) begin
                op_d  = xxh_pkg::OP_FOLD_A;
                idx_d = idx_q + 2'd1;
              end else begin
                state_d = fin_q ? xxh_pkg::ST_FIN : xxh_pkg::ST_INSERT;
              end
            end
            xxh_pkg::OP_MRG_A: op_d = xxh_pkg::OP_MRG_B;
            xxh_pkg::OP_MRG_B: op_d = xxh_pkg::OP_MRG_C;
            xxh_pkg::OP_MRG_C: begin
              if (idx_q != 2'd3) begin
                op_d  = xxh_pkg::OP_MRG_A;
                idx_d = idx_q + 2'd1;
              end else begin
                state_d = xxh_pkg::ST_ADDLEN;
              end
            end
            xxh_pkg::OP_T8_A: op_d = xxh_pkg::OP_T8_B;
            xxh_pkg::OP_T8_B: op_d = xxh_pkg::OP_T8_C;
            xxh_pkg::OP_T4_A: op_d = xxh_pkg::OP_T4_B;
            xxh_pkg::OP_T1_A: op_d = xxh_pkg::OP_T1_B;
            xxh_pkg::OP_AV_A: op_d = xxh_pkg::OP_AV_B;
            xxh_pkg::OP_AV_B: state_d = xxh_pkg::ST_EMIT;
            default:          state_d = xxh_pkg::ST_TAIL;
          endcase
        end
      end
      xxh_pkg::ST_FIN: begin
        if (stat_i.pb_full) begin
          cmd_o.fold_prep = 1'b1;
          op_d    = xxh_pkg::OP_FOLD_A;
          idx_d   = 2'd0;
          state_d = xxh_pkg::ST_ISSUE;
        end else begin
          cmd_o.merge = 1'b1;
          if (stat_i.seen) begin
            op_d    = xxh_pkg::OP_MRG_A;
            idx_d   = 2'd0;
            state_d = xxh_pkg::ST_ISSUE;
          end else begin
            state_d = xxh_pkg::ST_ADDLEN;
          end
        end
      end
      xxh_pkg::ST_ADDLEN: begin
        cmd_o.add_h_len = 1'b1;
        state_d = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_TAIL: begin
        state_d = xxh_pkg::ST_ISSUE;
        if (stat_i.t8) begin
          op_d = xxh_pkg::OP_T8_A;
        end else if (stat_i.t4) begin
          op_d = xxh_pkg::OP_T4_A;
        end else if (stat_i.t1) begin
          op_d = xxh_pkg::OP_T1_A;
        end else begin
          op_d = xxh_pkg::OP_AV_A;
        end
      end
      xxh_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          fin_d   = 1'b0;
          state_d = xxh_pkg::ST_IDLE;
        end
      end
      default: state_d = xxh_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/xxh_datapath.sv */
// Datapath: pending buffer, lanes, length, hash accumulator and output register.
`default_nettype none
module xxh_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [63:0]   cfg_wdata_i,
  input  wire logic [63:0]   data_word_i,
  input  wire logic [3:0]    byte_count_i,
  input  wire logic          last_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [63:0]        hash_value_o,
  input  wire xxh_pkg::cmd_t cmd_i,
  output xxh_pkg::stat_t     stat_o
);

  logic [63:0]  seed_q;
  logic [63:0]  word_q;
  logic [3:0]   n_q, rem_q;
  logic         last_q;
  logic [5:0]   pb_q, pos_q;
  logic [63:0]  len_q;
  logic         seen_q;
  logic [255:0] buf_q, buf_d;
  logic [63:0]  lane_q [4];
  logic [63:0]  h_q, t_q;
  logic         out_valid_q;
  logic [63:0]  out_q;

  logic [5:0]   avail;
  logic [3:0]   k;
  logic [255:0] wshift, bsh;
  logic [3:0]   n_in;
  logic [63:0]  mul_a, mul_b, prod;
  logic         mul_done;
  logic [63:0]  lane_sel, bufw_sel, bufw_pos, rotsum;

  xxh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  always_comb begin
    n_in   = (byte_count_i > xxh_pkg::WordBytes) ? xxh_pkg::WordBytes : byte_count_i;
    avail  = xxh_pkg::StripeBytes - pb_q;
    k      = ({2'b0, rem_q} > avail) ? avail[3:0] : rem_q;
    wshift = {192'b0, word_q} << {pb_q[4:0], 3'b000};
    for (int j = 0; j < 32; j++) begin
      if ((6'(j) >= pb_q) && (7'(j) < ({1'b0, pb_q} + {3'b0, k}))) begin
        buf_d[j*8 +: 8] = wshift[j*8 +: 8];
      end else begin
        buf_d[j*8 +: 8] = buf_q[j*8 +: 8];
      end
    end
    bsh      = buf_q >> {pos_q[4:0], 3'b000};
    lane_sel = lane_q[cmd_i.idx];
    bufw_sel = buf_q[{cmd_i.idx, 6'b0} +: 64];
    bufw_pos = buf_q[{pos_q[4:3], 6'b0} +: 64];
    rotsum   = xxh_pkg::rotl(lane_q[0], 1) + xxh_pkg::rotl(lane_q[1], 7) +
               xxh_pkg::rotl(lane_q[2], 12) + xxh_pkg::rotl(lane_q[3], 18);
    case (cmd_i.op)
      xxh_pkg::OP_FOLD_A: begin mul_a = bufw_sel;                       mul_b = xxh_pkg::P2; end
      xxh_pkg::OP_FOLD_B: begin mul_a = lane_sel;                       mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_MRG_A:  begin mul_a = lane_sel;                       mul_b = xxh_pkg::P2; end
      xxh_pkg::OP_MRG_B:  begin mul_a = t_q;                            mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_MRG_C:  begin mul_a = h_q;                            mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_T8_A:   begin mul_a = bufw_pos;                       mul_b = xxh_pkg::P2; end
      xxh_pkg::OP_T8_B:   begin mul_a = t_q;                            mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_T8_C:   begin mul_a = xxh_pkg::rotl(h_q, 27);         mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_T4_A:   begin mul_a = {32'b0, bsh[31:0]};             mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_T4_B:   begin mul_a = xxh_pkg::rotl(h_q, 23);         mul_b = xxh_pkg::P2; end
      xxh_pkg::OP_T1_A:   begin mul_a = {56'b0, bsh[7:0]};              mul_b = xxh_pkg::P5; end
      xxh_pkg::OP_T1_B:   begin mul_a = xxh_pkg::rotl(h_q, 11);         mul_b = xxh_pkg::P1; end
      xxh_pkg::OP_AV_A:   begin mul_a = h_q ^ (h_q >> 33);              mul_b = xxh_pkg::P2; end
      xxh_pkg::OP_AV_B:   begin mul_a = h_q ^ (h_q >> 29);              mul_b = xxh_pkg::P3; end
      default:            begin mul_a = h_q;                            mul_b = xxh_pkg::P1; end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      pb_q        <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      seen_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        rem_q <= n_in;
      end
      if (cmd_i.insert) begin
        rem_q <= rem_q - k;
        pb_q  <= pb_q + {2'b0, k};
      end
      if (cmd_i.add_len) begin
        len_q <= len_q + {60'b0, n_q};
      end
      if (mul_done) begin
        case (cmd_i.op)
          xxh_pkg::OP_FOLD_B: begin
            if (cmd_i.idx == 2'd3) begin
              pb_q   <= '0;
              seen_q <= 1'b1;
            end
          end
          xxh_pkg::OP_T8_C: pos_q <= pos_q + 6'd8;
          xxh_pkg::OP_T4_B: pos_q <= pos_q + 6'd4;
          xxh_pkg::OP_T1_B: pos_q <= pos_q + 6'd1;
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        pb_q        <= '0;
        pos_q       <= '0;
        len_q       <= '0;
        seen_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= data_word_i;
      n_q    <= n_in;
      last_q <= last_i;
    end
    if (cmd_i.insert) begin
      buf_q  <= buf_d;
      word_q <= word_q >> {k, 3'b000};
    end
    if (cmd_i.fold_prep && !seen_q) begin
      lane_q[0] <= seed_q + xxh_pkg::P1 + xxh_pkg::P2;
      lane_q[1] <= seed_q + xxh_pkg::P2;
      lane_q[2] <= seed_q;
      lane_q[3] <= seed_q - xxh_pkg::P1;
    end
    if (cmd_i.merge) begin
      h_q <= seen_q ? rotsum : seed_q + xxh_pkg::P5;
    end
    if (cmd_i.add_h_len) begin
      h_q <= h_q + len_q;
    end
    if (mul_done) begin
      case (cmd_i.op)
        xxh_pkg::OP_FOLD_A: lane_q[cmd_i.idx] <= xxh_pkg::rotl(lane_sel + prod, 31);
        xxh_pkg::OP_FOLD_B: lane_q[cmd_i.idx] <= prod;
        xxh_pkg::OP_MRG_A:  t_q <= xxh_pkg::rotl(prod, 31);
        xxh_pkg::OP_MRG_B:  h_q <= h_q ^ prod;
        xxh_pkg::OP_MRG_C:  h_q <= prod + xxh_pkg::P4;
        xxh_pkg::OP_T8_A:   t_q <= xxh_pkg::rotl(prod, 31);
        xxh_pkg::OP_T8_B:   h_q <= h_q ^ prod;
        xxh_pkg::OP_T8_C:   h_q <= prod + xxh_pkg::P4;
        xxh_pkg::OP_T4_A:   h_q <= h_q ^ prod;
        xxh_pkg::OP_T4_B:   h_q <= prod + xxh_pkg::P3;
        xxh_pkg::OP_T1_A:   h_q <= h_q ^ prod;
        default:            h_q <= prod;
      endcase
    end
    if (cmd_i.emit) begin
      out_q <= h_q ^ (h_q >> 32);
    end
  end

  always_comb begin
    stat_o.pb_full  = (pb_q == xxh_pkg::StripeBytes);
    stat_o.rem_nz   = (rem_q != 4'd0);
    stat_o.seen     = seen_q;
    stat_o.last     = last_q;
    stat_o.t8       = ({1'b0, pos_q} + 7'd8) <= {1'b0, pb_q};
    stat_o.t4       = ({1'b0, pos_q} + 7'd4) <= {1'b0, pb_q};
    stat_o.t1       = pos_q < pb_q;
    stat_o.mul_done = mul_done;
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

  a_pb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pb_q <= xxh_pkg::StripeBytes)
    else $error("pending byte count beyond one stripe");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= pb_q)
    else $error("tail position passed the pending bytes");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (pb_q != xxh_pkg::StripeBytes))
    else $error("insert into a full stripe buffer");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_valid_q && pb_q == 6'd0 && len_q == 64'd0 && !seen_q))
    else $error("message state not cleared after a result");

endmodule
`default_nettype wire
